// ===== hdl/trajectory_follower_pid_ff_assert.svh =====
// assertion macros for the trajectory follower
// expects clk and rst in the scope of the including module
`ifndef TRAJECTORY_FOLLOWER_PID_FF_ASSERT_SVH
`define TRAJECTORY_FOLLOWER_PID_FF_ASSERT_SVH

// same-cycle implication
`define TFPF_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trajectory follower assertion failed");

// next-cycle implication
`define TFPF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trajectory follower assertion failed");

`endif

// ===== hdl/tfpf_pkg.sv =====
// shared types, codes and helpers for the trajectory follower
// no dependencies
package tfpf_pkg;

  localparam int DW     = 32;
  localparam int ACC_W  = 52;
  localparam int PROD_W = 66;
  localparam int DIV_W  = 49;
  localparam int DIV_CW = 6;

  // segment memory depth, matches the 10-bit load index
  localparam int MAX_SEGMENTS = 1024;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] FRICTION = ACC_W'(3748);

  // action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_STEP  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_GAIN_P   = 3'd0;
  localparam logic [2:0] CFG_GAIN_I   = 3'd1;
  localparam logic [2:0] CFG_GAIN_D   = 3'd2;
  localparam logic [2:0] CFG_GAIN_VEL = 3'd3;
  localparam logic [2:0] CFG_GAIN_ACC = 3'd4;
  localparam logic [2:0] CFG_START    = 3'd5;
  localparam logic [2:0] CFG_DPC      = 3'd6;
  localparam logic [2:0] CFG_LENGTH   = 3'd7;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE, OP_DH, OP_DL, OP_DIST, OP_ERR, OP_SUM, OP_MI, OP_T, OP_MIT,
    OP_MP, OP_MV, OP_MA, OP_ADDF, OP_DQ, OP_MD, OP_ACCD, OP_OUT, OP_FOUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic div_done;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] accel;
    logic [30:0] period;
    logic [31:0] heading;
  } seg_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [DW-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/tfpf_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on tfpf_pkg
module tfpf_div import tfpf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [30:0]      divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  logic [30:0]       rem;
  logic [DIV_W-1:0]  quo;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [31:0]       trial;
  logic              fits;

  // trial subtraction
  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
      quo  <= dividend;
    end else if (busy) begin
      rem <= fits ? 31'(trial - {1'b0, divisor}) : trial[30:0];
      quo <= {quo[DIV_W-2:0], fits};
      cnt <= cnt + DIV_CW'(1);
      if (cnt == DIV_CW'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== hdl/tfpf_ctrl.sv =====
// step sequencer for the trajectory follower
// depends on tfpf_pkg
module tfpf_ctrl import tfpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  output logic       in_stall,
  input  status_t    status,
  output cmd_t       cmd
);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001, S_DH   = 19'h00002, S_DL   = 19'h00004,
    S_DIST = 19'h00008, S_ERR  = 19'h00010, S_SUM  = 19'h00020,
    S_MI   = 19'h00040, S_T    = 19'h00080, S_MIT  = 19'h00100,
    S_MP   = 19'h00200, S_MV   = 19'h00400, S_MA   = 19'h00800,
    S_ADDF = 19'h01000, S_WDIV = 19'h02000, S_DQ   = 19'h04000,
    S_MD   = 19'h08000, S_ACCD = 19'h10000, S_OUT  = 19'h20000,
    S_FOUT = 19'h40000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and command
  always_comb begin
    state_next = state;
    cmd.accept = accept;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (accept && action == ACT_STEP) begin
          state_next = status.finished ? S_FOUT : S_DH;
        end
      end
      S_DH:   begin cmd.op = OP_DH;   state_next = S_DL;   end
      S_DL:   begin cmd.op = OP_DL;   state_next = S_DIST; end
      S_DIST: begin cmd.op = OP_DIST; state_next = S_ERR;  end
      S_ERR:  begin cmd.op = OP_ERR;  state_next = S_SUM;  end
      S_SUM:  begin cmd.op = OP_SUM;  state_next = S_MI;   end
      S_MI:   begin cmd.op = OP_MI;   state_next = S_T;    end
      S_T:    begin cmd.op = OP_T;    state_next = S_MIT;  end
      S_MIT:  begin cmd.op = OP_MIT;  state_next = S_MP;   end
      S_MP:   begin cmd.op = OP_MP;   state_next = S_MV;   end
      S_MV:   begin cmd.op = OP_MV;   state_next = S_MA;   end
      S_MA:   begin cmd.op = OP_MA;   state_next = S_ADDF; end
      S_ADDF: begin cmd.op = OP_ADDF; state_next = S_WDIV; end
      S_WDIV: begin
        if (status.div_done) begin
          state_next = S_DQ;
        end
      end
      S_DQ:   begin cmd.op = OP_DQ;   state_next = S_MD;   end
      S_MD:   begin cmd.op = OP_MD;   state_next = S_ACCD; end
      S_ACCD: begin cmd.op = OP_ACCD; state_next = S_OUT;  end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      S_FOUT: begin
        if (status.out_free) begin
          cmd.op     = OP_FOUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/tfpf_dp.sv =====
// datapath: configuration, segment memory, shared multiplier, result register
// depends on tfpf_pkg and tfpf_div
module tfpf_dp import tfpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  action,
  input  logic [31:0] encoder_count,
  input  logic [9:0]  load_index,
  input  logic [31:0] load_position,
  input  logic [31:0] load_velocity,
  input  logic [31:0] load_accel,
  input  logic [30:0] load_period,
  input  logic [31:0] load_heading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] drive,
  output logic [31:0] heading_out,
  output logic        done_res,
  output logic [10:0] step_index
);

  localparam int AW = $clog2(MAX_SEGMENTS);

  // configuration
  logic signed [31:0] gain_p, gain_i, gain_d, gain_vel, gain_acc, start_count;
  logic [31:0]        distance_per_count;
  logic [10:0]        path_length;

  // follower state and working registers
  seg_t               mem [MAX_SEGMENTS];
  seg_t               mem_q;
  logic               len_zero;
  logic [10:0]        seg_ptr;
  logic signed [31:0] error_sum, prev_error;
  logic signed [32:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [31:0] travel, err, sum, t, deriv;
  logic               num_neg, num_zero;

  logic [10:0]        len_eff;
  logic [31:0]        rd_wide;
  logic [AW-1:0]      rd_addr;
  logic signed [32:0] mul_a, mul_b;
  logic signed [ACC_W-1:0] term;
  logic signed [32:0] num;
  logic [32:0]        num_mag;
  logic               div_start;
  logic [DIV_W-1:0]   quotient;
  logic               div_done;
  logic signed [ACC_W-1:0] q_wide;
  logic               out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0; gain_i <= '0; gain_d <= '0;
      gain_vel <= '0; gain_acc <= '0; start_count <= '0;
      distance_per_count <= '0; path_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GAIN_P:   gain_p <= cfg_data;
        CFG_GAIN_I:   gain_i <= cfg_data;
        CFG_GAIN_D:   gain_d <= cfg_data;
        CFG_GAIN_VEL: gain_vel <= cfg_data;
        CFG_GAIN_ACC: gain_acc <= cfg_data;
        CFG_START:    start_count <= cfg_data;
        CFG_DPC:      distance_per_count <= cfg_data;
        CFG_LENGTH:   path_length <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // path length clipped to the memory depth
  assign len_eff = (32'(path_length) > 32'(MAX_SEGMENTS)) ? 11'(MAX_SEGMENTS) : path_length;
  assign status.finished = seg_ptr >= len_eff;
  assign rd_wide = status.finished ? (32'(len_eff) - 32'd1) : 32'(seg_ptr);
  assign rd_addr = rd_wide[AW-1:0];

  // segment memory
  always_ff @(posedge clk) begin
    if (cmd.accept && action == ACT_LOAD && (32'(load_index) < 32'(MAX_SEGMENTS))) begin
      mem[load_index[AW-1:0]] <= '{load_position, load_velocity, load_accel,
                                   load_period, load_heading};
    end
    if (cmd.accept && action == ACT_STEP) begin
      mem_q <= mem[rd_addr];
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = diff;
    mul_b = $signed({17'b0, distance_per_count[31:16]});
    case (cmd.op)
      OP_DL:  mul_b = $signed({17'b0, distance_per_count[15:0]});
      OP_MI:  begin mul_a = 33'(gain_i);   mul_b = 33'(sum); end
      OP_MIT: begin mul_a = 33'(t);        mul_b = $signed({2'b0, mem_q.period}); end
      OP_MP:  begin mul_a = 33'(gain_p);   mul_b = 33'(err); end
      OP_MV:  begin mul_a = 33'(gain_vel); mul_b = 33'($signed(mem_q.velocity)); end
      OP_MA:  begin mul_a = 33'(gain_acc); mul_b = 33'($signed(mem_q.accel)); end
      OP_MD:  begin mul_a = 33'(gain_d);   mul_b = 33'(deriv); end
      default: ;
    endcase
  end

  // product floored by 2^16
  assign term = ACC_W'($signed(prod[PROD_W-1:16]));

  // derivative numerator as sign and magnitude
  assign num       = 33'(err) - 33'(prev_error);
  assign num_mag   = num[32] ? 33'(-num) : 33'(num);
  assign div_start = cmd.op == OP_SUM;

  tfpf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num_mag, 16'b0}),
    .divisor  (mem_q.period),
    .quotient (quotient),
    .done     (div_done)
  );

  assign q_wide          = $signed({3'b0, quotient});
  assign status.div_done = div_done;
  assign out_free        = !out_valid || !out_stall;
  assign status.out_free = out_free;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept && action == ACT_STEP) begin
      diff     <= 33'(signed'(encoder_count)) - 33'(start_count);
      len_zero <= len_eff == 11'd0;
    end
    case (cmd.op)
      OP_DH, OP_MI, OP_MIT, OP_MD: prod <= mul_a * mul_b;
      OP_DL: begin
        prod <= mul_a * mul_b;
        acc  <= prod[ACC_W-1:0];
      end
      OP_DIST: travel <= sat32(acc + term);
      OP_ERR:  err  <= sat32(ACC_W'($signed(mem_q.position)) - ACC_W'(travel));
      OP_SUM: begin
        sum      <= sat32(ACC_W'(error_sum) + ACC_W'(err));
        num_neg  <= num[32];
        num_zero <= num == 33'sd0;
      end
      OP_T: t <= sat32(term);
      OP_MP: begin
        prod <= mul_a * mul_b;
        acc  <= term;
      end
      OP_MV, OP_MA: begin
        prod <= mul_a * mul_b;
        acc  <= acc + term;
      end
      OP_ADDF: acc <= acc + term + (($signed(mem_q.velocity) > 32'sd0) ? FRICTION : -FRICTION);
      OP_DQ: begin
        if (num_zero) begin
          deriv <= '0;
        end else begin
          deriv <= num_neg ? sat32(-q_wide) : sat32(q_wide);
        end
      end
      OP_ACCD: acc <= acc + term;
      default: ;
    endcase
  end

  // follower state
  always_ff @(posedge clk) begin
    if (rst || (cmd.accept && action == ACT_RESET)) begin
      seg_ptr    <= '0;
      error_sum  <= '0;
      prev_error <= '0;
    end else if (cmd.op == OP_OUT) begin
      seg_ptr    <= seg_ptr + 11'd1;
      error_sum  <= sum;
      prev_error <= err;
    end else if (cmd.op == OP_FOUT) begin
      error_sum <= '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT || cmd.op == OP_FOUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      drive       <= sat32(acc);
      heading_out <= mem_q.heading;
      done_res    <= 1'b0;
      step_index  <= seg_ptr;
    end else if (cmd.op == OP_FOUT) begin
      drive       <= '0;
      heading_out <= len_zero ? '0 : mem_q.heading;
      done_res    <= 1'b1;
      step_index  <= seg_ptr;
    end
  end

endmodule

// ===== hdl/trajectory_follower_pid_ff.sv =====
// top level of the trajectory follower: sequencer plus datapath
// depends on tfpf_pkg, tfpf_ctrl, tfpf_dp and the assertion header
//
// Usage: input transactions carry an action. A load writes one segment
// (position, velocity, acceleration, dt, heading) into the segment memory,
// a reset clears the segment pointer, error sum and previous error, and a
// step converts the encoder count to distance and produces one result with
// PID plus feedforward drive, heading, finished flag and segment index.
// Loads and resets give no result. A step runs a chain of single-multiplier
// steps, while a restoring divider works out the derivative; the sequencer
// waits for the divider before using the quotient. A step past the end of
// the path skips these steps. One item is worked on at a time; in_stall is
// high while a step runs. The result register lets the next item enter while
// a result waits; a step that finishes while out_stall holds the previous
// result waits in its last state. Configuration writes are always taken
// (cfg_ready is high). Synchronous reset clears the control state and the
// follower state; the segment memory keeps its contents.
module trajectory_follower_pid_ff import tfpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] encoder_count,
  input  logic [9:0]  load_index,
  input  logic [31:0] load_position,
  input  logic [31:0] load_velocity,
  input  logic [31:0] load_accel,
  input  logic [30:0] load_period,
  input  logic [31:0] load_heading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] drive,
  output logic [31:0] heading_out,
  output logic        done_res,
  output logic [10:0] step_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "trajectory_follower_pid_ff_assert.svh"

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tfpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tfpf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .encoder_count (encoder_count),
    .load_index    (load_index),
    .load_position (load_position),
    .load_velocity (load_velocity),
    .load_accel    (load_accel),
    .load_period   (load_period),
    .load_heading  (load_heading),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive         (drive),
    .heading_out   (heading_out),
    .done_res      (done_res),
    .step_index    (step_index)
  );

  // a result is only written into a free result register
  `TFPF_ASSERT_NOW(a_out_free, (cmd.op == OP_OUT || cmd.op == OP_FOUT), status.out_free)
  // an accepted step holds off the input side
  `TFPF_ASSERT_NEXT(a_step_busy, (in_valid && !in_stall && action == ACT_STEP), in_stall)
  // a new result follows a step that was in flight
  `TFPF_ASSERT_NOW(a_result_src, $rose(out_valid), $past(in_stall))

endmodule
